// ===== rtl/kcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_pkg
// shared types and constants of the key command sequencer: command codes,
// default sizes and the command/status groups between controller and datapath
// ----------------------------------------------------------------------------
package kcs_pkg;

    // item operations carried on the slave-side tuser
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    // queued command types
    localparam logic [1:0] TYPE_PRESS   = 2'd0;
    localparam logic [1:0] TYPE_RELEASE = 2'd1;
    localparam logic [1:0] TYPE_WAIT    = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int ROW_COUNT_DEF   = 12;
    localparam int RUN_LIMIT_DEF   = 63;

    localparam logic [15:0] MAX_WAIT_RST = 16'd60000;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam int RES_W      = 33;  // packed result fields without padding
    localparam int QUEUED_W   = 11;
    localparam int ENTRY_W    = 22;  // type 2, row 4, value 16

    typedef struct packed {
        logic cap;         // latch the input item
        logic run_clear;   // new tick: clear the per-tick command count
        logic stop_clear;  // empty the queue, drop the wait, restart the row scan
        logic push;        // check the latched command, store it, answer
        logic wait_step;   // count down the running wait
        logic exec;        // run the head press/release command
        logic start_wait;  // load the wait counter from the head command
        logic scan_inc;    // skip a row with nothing held
        logic stop_row;    // release the scanned row
        logic flush;       // send the pending result as the final one
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic pend_valid;
        logic wait_active;
        logic wait_one;
        logic fill_zero;
        logic head_is_wait;
        logic run_at_limit;
        logic scan_done;
        logic scan_held_nz;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/kcs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_ctrl
// sequencing state machine: takes one item at a time and steps the datapath
// through push, tick playback or stop release
// ----------------------------------------------------------------------------
module kcs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire [1:0]           i_op,
    output logic                o_ready,
    input  kcs_pkg::t_dp_status i_status,
    output kcs_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_TSTART,
        S_RD,
        S_EXEC,
        S_STOP,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   n_ready;
    logic   r_ready;

    // a result may be produced when the pending slot is free or can move out
    logic emit_ok;

    assign emit_ok = !i_status.pend_valid || i_status.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    case (i_op)
                        kcs_pkg::OP_PUSH: n_state = S_PUSH;
                        kcs_pkg::OP_TICK: begin
                            o_cmd.run_clear = 1'b1;
                            n_state         = S_TSTART;
                        end
                        kcs_pkg::OP_STOP: begin
                            o_cmd.stop_clear = 1'b1;
                            n_state          = S_STOP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TSTART: begin
                if (i_status.wait_active) begin
                    o_cmd.wait_step = 1'b1;
                    n_state         = i_status.wait_one ? S_RD : S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.fill_zero) begin
                    n_state = S_FLUSH;
                end else if (i_status.head_is_wait) begin
                    o_cmd.start_wait = 1'b1;
                    n_state          = S_FLUSH;
                end else if (i_status.run_at_limit) begin
                    n_state = S_FLUSH;
                end else if (emit_ok) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_STOP: begin
                if (i_status.scan_done) begin
                    n_state = S_FLUSH;
                end else if (!i_status.scan_held_nz) begin
                    o_cmd.scan_inc = 1'b1;
                end else if (emit_ok) begin
                    o_cmd.stop_row = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_ready = (n_state == S_IDLE);
    assign o_ready = r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_status.pend_valid)
        else $error("result left pending while idle");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

endmodule
`default_nettype wire

// ===== rtl/kcs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_dp
// datapath: command queue memory with pointers and fill count, wait counter,
// held key masks per row, pending result slot and output register
// ----------------------------------------------------------------------------
module kcs_dp #(
    parameter int QUEUE_DEPTH = kcs_pkg::QUEUE_DEPTH_DEF,
    parameter int ROW_COUNT   = kcs_pkg::ROW_COUNT_DEF,
    parameter int RUN_LIMIT   = kcs_pkg::RUN_LIMIT_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  kcs_pkg::t_dp_cmd                   i_cmd,
    output kcs_pkg::t_dp_status                o_status,
    input  wire [kcs_pkg::IN_DATA_W-1:0]       i_tdata,
    input  wire                                i_cfg_valid,
    input  wire [15:0]                         i_cfg_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [kcs_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic                               o_out_kind,
    output logic                               o_out_last
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SCAN_W = $clog2(ROW_COUNT + 1);
    localparam int RUN_W  = $clog2(RUN_LIMIT + 1);
    localparam logic [4:0]       ROW_LIM  = 5'(ROW_COUNT);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    logic [kcs_pkg::ENTRY_W-1:0] r_cmd_mem [QUEUE_DEPTH];
    logic [kcs_pkg::ENTRY_W-1:0] r_rd_data;

    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [FILL_W-1:0] r_fill;
    logic [15:0]       r_wait;
    logic [7:0]        r_held [ROW_COUNT];
    logic [RUN_W-1:0]  r_run;
    logic [SCAN_W-1:0] r_scan;
    logic [15:0]       r_max_wait;

    logic [1:0]  r_type;
    logic [3:0]  r_row;
    logic [15:0] r_val;

    logic                        r_pend_valid;
    logic [kcs_pkg::RES_W-1:0]   r_pend_data;
    logic                        r_out_valid;
    logic [kcs_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                        r_out_kind;
    logic                        r_out_last;

    // push check
    logic                        push_ok;
    logic [kcs_pkg::ENTRY_W-1:0] push_entry;
    logic [FILL_W-1:0]           n_fill_push;

    // head command
    logic [1:0]        head_type;
    logic [3:0]        head_row;
    logic [7:0]        head_mask;
    logic [15:0]       head_val;
    logic [ROW_W-1:0]  head_idx;
    logic              head_in_range;
    logic [7:0]        head_held;
    logic [7:0]        n_held;
    logic [FILL_W-1:0] fill_dec;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [ROW_W-1:0]  scan_idx;
    logic [7:0]        scan_held;

    logic out_free;
    logic [kcs_pkg::RES_W-1:0] exec_res;
    logic [kcs_pkg::RES_W-1:0] stop_res;

    always_comb begin
        push_ok = 1'b0;
        case (r_type)
            kcs_pkg::TYPE_PRESS,
            kcs_pkg::TYPE_RELEASE: push_ok = ({1'b0, r_row} < ROW_LIM) &&
                                             (r_val != 16'd0) && (r_val <= 16'd255);
            kcs_pkg::TYPE_WAIT:    push_ok = (r_val <= r_max_wait);
            default:               push_ok = 1'b0;
        endcase
        if (r_fill == FILL_MAX) begin
            push_ok = 1'b0;
        end
    end

    assign push_entry  = {r_type, (r_type == kcs_pkg::TYPE_WAIT) ? 4'd0 : r_row, r_val};
    assign n_fill_push = r_fill + FILL_W'(push_ok);

    assign head_type     = r_rd_data[21:20];
    assign head_row      = r_rd_data[19:16];
    assign head_mask     = r_rd_data[7:0];
    assign head_val      = r_rd_data[15:0];
    assign head_idx      = head_row[ROW_W-1:0];
    assign head_in_range = ({1'b0, head_row} < ROW_LIM);
    assign head_held     = head_in_range ? r_held[head_idx] : 8'd0;
    assign n_held        = !head_in_range ? 8'd0 :
                           (head_type == kcs_pkg::TYPE_PRESS) ? (head_held | head_mask) :
                                                                (head_held & ~head_mask);

    assign fill_dec   = r_fill - FILL_W'(1);
    assign rd_ptr_inc = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
    assign wr_ptr_inc = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
    assign scan_idx   = r_scan[ROW_W-1:0];
    assign scan_held  = r_held[scan_idx];

    // result fields from the low bit up: accepted, row, mask, pressed, held, queued
    assign exec_res = {kcs_pkg::QUEUED_W'(fill_dec), n_held,
                       (head_type == kcs_pkg::TYPE_PRESS), head_mask, head_row, 1'b0};
    assign stop_res = {kcs_pkg::QUEUED_W'(0), 8'd0, 1'b0, scan_held, 4'(scan_idx), 1'b0};

    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.out_free     = out_free;
    assign o_status.pend_valid   = r_pend_valid;
    assign o_status.wait_active  = (r_wait != 16'd0);
    assign o_status.wait_one     = (r_wait == 16'd1);
    assign o_status.fill_zero    = (r_fill == '0);
    assign o_status.head_is_wait = (head_type == kcs_pkg::TYPE_WAIT);
    assign o_status.run_at_limit = (r_run == RUN_W'(RUN_LIMIT));
    assign o_status.scan_done    = (r_scan == SCAN_W'(ROW_COUNT));
    assign o_status.scan_held_nz = (scan_held != 8'd0);

    // queue memory, registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && push_ok) begin
            r_cmd_mem[r_wr_ptr] <= push_entry;
        end
        r_rd_data <= r_cmd_mem[r_rd_ptr];
    end

    // latched item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_type <= i_tdata[1:0];
            r_row  <= i_tdata[5:2];
            r_val  <= i_tdata[21:6];
        end
        if (i_cmd.exec) begin
            r_pend_data <= exec_res;
        end else if (i_cmd.stop_row) begin
            r_pend_data <= stop_res;
        end
        if (i_cmd.push) begin
            r_out_data <= kcs_pkg::OUT_DATA_W'({kcs_pkg::QUEUED_W'(n_fill_push), 21'd0, push_ok});
            r_out_kind <= 1'b0;
            r_out_last <= 1'b1;
        end else if (((i_cmd.exec || i_cmd.stop_row) && r_pend_valid) || i_cmd.flush) begin
            r_out_data <= kcs_pkg::OUT_DATA_W'(r_pend_data);
            r_out_kind <= 1'b1;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_fill       <= '0;
            r_wait       <= 16'd0;
            r_held       <= '{default: 8'd0};
            r_run        <= '0;
            r_scan       <= '0;
            r_max_wait   <= kcs_pkg::MAX_WAIT_RST;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_wait <= i_cfg_data;
            end
            if (i_cmd.run_clear) begin
                r_run <= '0;
            end
            if (i_cmd.stop_clear) begin
                r_rd_ptr <= '0;
                r_wr_ptr <= '0;
                r_fill   <= '0;
                r_wait   <= 16'd0;
                r_scan   <= '0;
            end
            if (i_cmd.push && push_ok) begin
                r_wr_ptr <= wr_ptr_inc;
                r_fill   <= n_fill_push;
            end
            if (i_cmd.wait_step) begin
                r_wait <= r_wait - 16'd1;
                // the wait leaves the queue on the tick that ends it
                if (r_wait == 16'd1 && r_fill != '0) begin
                    r_rd_ptr <= rd_ptr_inc;
                    r_fill   <= fill_dec;
                end
            end
            if (i_cmd.start_wait) begin
                r_wait <= (head_val == 16'd0) ? 16'd1 : head_val;
            end
            if (i_cmd.exec) begin
                if (head_in_range) begin
                    r_held[head_idx] <= n_held;
                end
                r_rd_ptr <= rd_ptr_inc;
                r_fill   <= fill_dec;
                r_run    <= r_run + RUN_W'(1);
            end
            if (i_cmd.scan_inc || i_cmd.stop_row) begin
                r_scan <= r_scan + SCAN_W'(1);
            end
            if (i_cmd.stop_row) begin
                r_held[scan_idx] <= 8'd0;
            end

            if (i_cmd.exec || i_cmd.stop_row) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end

            if (i_cmd.push || ((i_cmd.exec || i_cmd.stop_row) && r_pend_valid) ||
                i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("queue fill beyond depth");

    a_wait_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != 16'd0) |-> (r_fill != '0))
        else $error("wait running with an empty queue");

    a_push_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !r_pend_valid)
        else $error("push answer would overtake a pending result");

    a_exec_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.stop_row) |=> r_pend_valid)
        else $error("row change not held pending");

endmodule
`default_nettype wire

// ===== rtl/key_command_sequencer_top.sv =====
`default_nettype none
// a push is answered from the output register once the latched command is checked;
// a tick runs each press/release as a queue memory read, then an execute step,
// after the wait check, and ends with a final head read and the flush; a stop
// scans the matrix rows one at a time, then ends the scan and flushes.
// throughput: one item at a time; the next item is taken once the last result
// of the current one is in the output register (it need not be taken yet).
// reset: queue empty, no wait, nothing held, max_wait 60000; the queue memory
// is not cleared (entries are only read after written), so no clearing pass.
// ----------------------------------------------------------------------------
// key_command_sequencer_top
// keyboard matrix command queue: checks and stores press/release/wait commands
// and plays them back on millisecond ticks
// ----------------------------------------------------------------------------
module key_command_sequencer_top #(
    parameter int QUEUE_DEPTH = kcs_pkg::QUEUE_DEPTH_DEF,
    parameter int ROW_COUNT   = kcs_pkg::ROW_COUNT_DEF,
    parameter int RUN_LIMIT   = kcs_pkg::RUN_LIMIT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [kcs_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // cmd_type, row, value
    input  wire [1:0]                      s_axis_tuser,   // op
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [kcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // accepted, key_row, key_mask,
                                                           // pressed, row_held, queued
    output logic                           m_axis_tuser,   // kind
    output logic                           m_axis_tlast,   // last
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [15:0]                     i_cfg_data      // max_wait
);

    kcs_pkg::t_dp_cmd    cmd;
    kcs_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    kcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    kcs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ROW_COUNT   (ROW_COUNT),
        .RUN_LIMIT   (RUN_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_tdata     (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the key command sequencer: a directed table, random
// pushes, ticks and stops under random backpressure, a run past the per-tick
// limit, more random items; every result compared against a behavioral model of the queue
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] OP_NONE  = 2'd3;
    localparam logic [1:0] TYPE_BAD = 2'd3;

    // how a directed row is checked
    localparam logic [1:0] ANS_REJECT  = 2'd0;
    localparam logic [1:0] ANS_ACCEPT  = 2'd1;
    localparam logic [1:0] ANS_PREDICT = 2'd2;

    localparam int ROWS           = kcs_pkg::ROW_COUNT_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS    = 100;
    localparam int DIRECTED_ROWS  = 27;
    localparam int LIMIT_PUSHES   = kcs_pkg::RUN_LIMIT_DEF + 4;

    typedef struct packed {
        logic [1:0]  ctype;
        logic [3:0]  row;
        logic [15:0] value;
    } t_key_cmd;

    typedef struct packed {
        logic        kind;
        logic        accepted;
        logic [3:0]  key_row;
        logic [7:0]  key_mask;
        logic        pressed;
        logic [7:0]  row_held;
        logic [10:0] queued;
        logic        last;
    } t_key_result;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  op;
        logic [1:0]  ctype;
        logic [3:0]  row;
        logic [15:0] value;
        logic [1:0]  answer;
    } t_stim_row;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [kcs_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]                     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [kcs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [15:0]                    i_cfg_data    = '0;

    // model state
    t_key_cmd    queued_cmds[$];
    t_key_result expected_results[$];
    logic [7:0]  held_rows [ROWS];
    int          wait_left    = 0;
    int          cfg_max_wait = int'(kcs_pkg::MAX_WAIT_RST);

    int mismatches    = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_hold_count = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;
    bit offering      = 0;

    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{1'b0, kcs_pkg::OP_TICK, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_STOP, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd0,  16'h00ff,  ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_RELEASE, 4'd11, 16'h0001,  ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd5,  16'h000f,  ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_WAIT,    4'd0,  16'd0,     ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd5,  16'h00f0,  ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd12, 16'h0001,  ANS_REJECT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_RELEASE, 4'd15, 16'h00ff,  ANS_REJECT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd0,  16'h0000,  ANS_REJECT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd3,  16'hffff,  ANS_REJECT},
        '{1'b0, kcs_pkg::OP_PUSH, TYPE_BAD,              4'd0,  16'h0001,  ANS_REJECT},
        '{1'b0, kcs_pkg::OP_TICK, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_TICK, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_WAIT,    4'd0,  16'd60000, ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_WAIT,    4'd9,  16'd60001, ANS_REJECT},
        '{1'b0, kcs_pkg::OP_TICK, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b0, OP_NONE,          TYPE_BAD,              4'd15, 16'hffff,  ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_STOP, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b1, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_WAIT,    4'd0,  16'd0,     ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_WAIT,    4'd0,  16'd1,     ANS_REJECT},
        '{1'b0, kcs_pkg::OP_TICK, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_TICK, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT},
        '{1'b1, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_PRESS,   4'd0,  16'hffff,  ANS_PREDICT},
        '{1'b0, kcs_pkg::OP_PUSH, kcs_pkg::TYPE_WAIT,    4'd15, 16'hffff,  ANS_ACCEPT},
        '{1'b0, kcs_pkg::OP_STOP, kcs_pkg::TYPE_PRESS,   4'd0,  16'd0,     ANS_PREDICT}
    };

    key_command_sequencer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------
    function automatic void post_result(logic kind, logic acc, logic [3:0] r,
                                        logic [7:0] m, logic down, logic [7:0] h);
        t_key_result res;
        res          = '0;
        res.kind     = kind;
        res.accepted = acc;
        res.key_row  = r;
        res.key_mask = m;
        res.pressed  = down;
        res.row_held = h;
        res.queued   = 11'(queued_cmds.size());
        expected_results.push_back(res);
    endfunction

    function automatic void mark_last();
        expected_results[expected_results.size()-1].last = 1'b1;
    endfunction

    function automatic void predict_push(logic [1:0] ctype, logic [3:0] r, logic [15:0] v);
        logic     ok;
        t_key_cmd cmd;
        case (ctype)
            kcs_pkg::TYPE_PRESS,
            kcs_pkg::TYPE_RELEASE: ok = (r < ROWS) && (v >= 1) && (v <= 255);
            kcs_pkg::TYPE_WAIT:    ok = (v <= cfg_max_wait);
            default:               ok = 1'b0;
        endcase
        if (queued_cmds.size() >= kcs_pkg::QUEUE_DEPTH_DEF)
            ok = 1'b0;
        if (ok) begin
            cmd.ctype = ctype;
            cmd.row   = (ctype == kcs_pkg::TYPE_WAIT) ? 4'd0 : r;
            cmd.value = v;
            queued_cmds.push_back(cmd);
        end
        post_result(1'b0, ok, 4'd0, 8'd0, 1'b0, 8'd0);
        mark_last();
    endfunction

    function automatic void predict_tick();
        int         ran;
        t_key_cmd   head;
        logic [7:0] h;
        ran = 0;
        if (wait_left > 0) begin
            wait_left--;
            if (wait_left > 0)
                return;
            if (queued_cmds.size() > 0)
                void'(queued_cmds.pop_front());
        end
        while (queued_cmds.size() > 0) begin
            head = queued_cmds[0];
            // a wait at the head starts even when the run limit is used up
            if (head.ctype == kcs_pkg::TYPE_WAIT) begin
                wait_left = (head.value == 0) ? 1 : int'(head.value);
                break;
            end
            if (ran >= kcs_pkg::RUN_LIMIT_DEF)
                break;
            h = held_rows[head.row];
            h = (head.ctype == kcs_pkg::TYPE_PRESS) ? (h | head.value[7:0]) :
                                                      (h & ~head.value[7:0]);
            held_rows[head.row] = h;
            void'(queued_cmds.pop_front());
            post_result(1'b1, 1'b0, head.row, head.value[7:0],
                        head.ctype == kcs_pkg::TYPE_PRESS, h);
            ran++;
        end
        if (ran > 0)
            mark_last();
    endfunction

    function automatic void predict_stop();
        int released;
        released = 0;
        queued_cmds.delete();
        wait_left = 0;
        for (int r = 0; r < ROWS; r++) begin
            if (held_rows[r] != 0) begin
                post_result(1'b1, 1'b0, 4'(r), held_rows[r], 1'b0, 8'd0);
                held_rows[r] = 8'd0;
                released++;
            end
        end
        if (released > 0)
            mark_last();
    endfunction

    // ------------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------------
    task automatic send_item(logic [1:0] op, logic [1:0] ctype, logic [3:0] r,
                             logic [15:0] v, logic [1:0] answer);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, v, r, ctype};
        offering = 1;
        do @(posedge i_clk); while (!s_axis_tready);
        case (op)
            kcs_pkg::OP_PUSH: predict_push(ctype, r, v);
            kcs_pkg::OP_TICK: predict_tick();
            kcs_pkg::OP_STOP: predict_stop();
            default: ;
        endcase
        if (op == kcs_pkg::OP_PUSH && answer != ANS_PREDICT)
            expected_results[expected_results.size()-1].accepted = answer[0];
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            if (offering)
                s_axis_tvalid <= 1'b0;
            offering = 0;
            @(posedge i_clk);
        end
    endtask

    task automatic stop_offering();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 0;
            @(posedge i_clk);
        end
    endtask

    task automatic await_all_results();
        stop_offering();
        while (expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_max_wait(logic [15:0] v);
        await_all_results();
        // a tick that only counts a wait down leaves no result behind
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_max_wait = int'(v);
    endtask

    task automatic send_random_push();
        int          pick;
        int          small_cap;
        logic [1:0]  ct;
        logic [3:0]  r;
        logic [15:0] v;
        pick      = $urandom_range(0, 99);
        small_cap = (cfg_max_wait < 3) ? cfg_max_wait : 3;
        r         = 4'($urandom_range(0, ROWS - 1));
        v         = 16'($urandom_range(1, 255));
        ct        = (pick < 36) ? kcs_pkg::TYPE_PRESS : kcs_pkg::TYPE_RELEASE;
        if (pick >= 72 && pick < 85) begin
            ct = kcs_pkg::TYPE_WAIT;
            r  = 4'($urandom);
            if (pick < 80)
                v = 16'($urandom_range(0, small_cap));
            else if (pick < 83)
                v = 16'(cfg_max_wait);
            else
                v = 16'($urandom_range(0, cfg_max_wait));
        end else if (pick >= 85) begin
            case ($urandom_range(0, 3))
                0: begin
                    ct = TYPE_BAD;
                    r  = 4'($urandom);
                    v  = 16'($urandom);
                end
                1: begin
                    ct = 2'($urandom_range(0, 1));
                    r  = 4'($urandom_range(ROWS, 15));
                end
                2: begin
                    ct = 2'($urandom_range(0, 1));
                    v  = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(256, 65535));
                end
                default: begin
                    if (cfg_max_wait < 65535) begin
                        ct = kcs_pkg::TYPE_WAIT;
                        v  = 16'($urandom_range(cfg_max_wait + 1, 65535));
                    end else begin
                        ct = TYPE_BAD;
                    end
                end
            endcase
        end
        send_item(kcs_pkg::OP_PUSH, ct, r, v, ANS_PREDICT);
    endtask

    task automatic run_random(int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_random_push();
            end else if (pick < 88) begin
                send_item(kcs_pkg::OP_TICK, 2'($urandom), 4'($urandom), 16'($urandom),
                          ANS_PREDICT);
            end else if (pick < 95) begin
                send_item(kcs_pkg::OP_STOP, 2'($urandom), 4'($urandom), 16'($urandom),
                          ANS_PREDICT);
            end else begin
                send_item(OP_NONE, 2'($urandom), 4'($urandom), 16'($urandom), ANS_PREDICT);
                continue;
            end
            sent++;
        end
    endtask

    // queues more commands than one tick may run, with a wait right at the limit
    task automatic run_limit_check();
        send_item(kcs_pkg::OP_STOP, kcs_pkg::TYPE_PRESS, 4'd0, 16'd0, ANS_PREDICT);
        for (int k = 0; k < LIMIT_PUSHES; k++) begin
            if (k == kcs_pkg::RUN_LIMIT_DEF)
                send_item(kcs_pkg::OP_PUSH, kcs_pkg::TYPE_WAIT, 4'd0, 16'd1, ANS_ACCEPT);
            else
                send_item(kcs_pkg::OP_PUSH, 2'($urandom_range(0, 1)),
                          4'($urandom_range(0, ROWS - 1)),
                          16'($urandom_range(1, 255)), ANS_ACCEPT);
        end
        repeat (4) send_item(kcs_pkg::OP_TICK, kcs_pkg::TYPE_PRESS, 4'd0, 16'd0, ANS_PREDICT);
        send_item(kcs_pkg::OP_STOP, kcs_pkg::TYPE_PRESS, 4'd0, 16'd0, ANS_PREDICT);
    endtask

    initial begin
        for (int r = 0; r < ROWS; r++)
            held_rows[r] = 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 36;
        rx_idle_pct <= 82;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].is_cfg)
                write_max_wait(directed_rows[i].value);
            else
                send_item(directed_rows[i].op, directed_rows[i].ctype, directed_rows[i].row,
                          directed_rows[i].value, directed_rows[i].answer);
        end
        write_max_wait(16'd5);
        run_random(PHASE_ITEMS);

        tx_idle_pct = 82;
        rx_idle_pct <= 36;
        write_max_wait(16'hffff);
        run_random(PHASE_ITEMS / 2);
        await_all_results();
        run_random(PHASE_ITEMS / 2);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_limit_check();
        write_max_wait(16'($urandom_range(0, 65535)));
        // receiver stalls for a long stretch while items keep coming
        rx_hold_count <= rx_hold_count + 1;
        run_random(PHASE_ITEMS);

        await_all_results();
        repeat (32) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_count != rx_hold_seen) begin
            rx_hold_seen = rx_hold_count;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_key_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind",     16'(want.kind),     16'(m_axis_tuser));
                check_field("accepted", 16'(want.accepted), 16'(m_axis_tdata[0]));
                check_field("key_row",  16'(want.key_row),  16'(m_axis_tdata[4:1]));
                check_field("key_mask", 16'(want.key_mask), 16'(m_axis_tdata[12:5]));
                check_field("pressed",  16'(want.pressed),  16'(m_axis_tdata[13]));
                check_field("row_held", 16'(want.row_held), 16'(m_axis_tdata[21:14]));
                check_field("queued",   16'(want.queued),   16'(m_axis_tdata[32:22]));
                check_field("last",     16'(want.last),     16'(m_axis_tlast));
            end
        end
    end

endmodule
`default_nettype wire
